[rtl/dcc_pkg.sv]
`default_nettype none
package dcc_pkg;

   localparam int BUCKETS        = 4096;
   localparam int MAX_WAYS       = 16;
   localparam int ARRAY_CONTEXTS = 65536;
   localparam int COUNTER_BITS   = 16;
   localparam int KEY_BITS       = 8;
   localparam int SYMS           = 4;
   localparam int NIB            = 4;

   localparam int BUCKET_BITS = $clog2(BUCKETS);
   localparam int WAY_BITS    = $clog2(MAX_WAYS);
   localparam int WAYS_W      = $clog2(MAX_WAYS + 1);
   localparam int CTX_BITS    = $clog2(ARRAY_CONTEXTS);
   localparam int NCNT_BITS   = SYMS * NIB;
   localparam int ENTRY_BITS  = KEY_BITS + NCNT_BITS;
   localparam int ROW_BITS    = MAX_WAYS * ENTRY_BITS;
   localparam int ACNT_BITS   = SYMS * COUNTER_BITS;
   localparam int CLR_BITS    = CTX_BITS;
   localparam int HKEEP       = (BUCKET_BITS > KEY_BITS) ? BUCKET_BITS : KEY_BITS;
   localparam int FRONT_STAGES = 4;

   localparam logic [1:0] CSR_TABLE_MODE  = 2'd0;
   localparam logic [1:0] CSR_WAYS_IN_USE = 2'd1;
   localparam logic [1:0] CSR_ALPHA_DEN   = 2'd2;
   localparam logic [1:0] CSR_MAX_COUNT   = 2'd3;

   localparam logic FUNC_LOOKUP = 1'b0;
   localparam logic FUNC_UPDATE = 1'b1;
   localparam logic MODE_ARRAY  = 1'b0;
   localparam logic MODE_HASH   = 1'b1;

   typedef struct packed {
      logic                   func;
      logic [1:0]             symbol;
      logic [CTX_BITS-1:0]    ctx;
      logic [HKEEP-1:0]       hbits;
   } item_type;

   typedef struct packed {
      logic        hash_mode;
      logic [4:0]  ways_in_use;
      logic [11:0] alpha_den;
      logic [15:0] max_count;
   } cfg_type;

   typedef struct packed {
      logic [SYMS-1:0][27:0] wfreq;
      logic [29:0]           wtotal;
      logic [SYMS-1:0][16:0] pfreq;
      logic [18:0]           ptotal;
      logic                  hit;
   } result_type;

   typedef struct packed {
      logic       clearing;
      logic [1:0] rsp_count;
   } back_status_type;

   function automatic logic [63:0] mix_a(input logic [63:0] z);
      logic [63:0] t;
      t = (~z) + (z << 21);
      return t ^ (t >> 24);
   endfunction

   function automatic logic [63:0] mix_b(input logic [63:0] z);
      logic [63:0] t;
      t = z + (z << 3) + (z << 8);
      return t ^ (t >> 14);
   endfunction

   function automatic logic [63:0] mix_c(input logic [63:0] z);
      logic [63:0] t;
      t = z + (z << 2) + (z << 4);
      return t ^ (t >> 28);
   endfunction

   function automatic logic [63:0] mix_d(input logic [63:0] z);
      return z + (z << 31);
   endfunction

endpackage
`default_nettype wire

[rtl/dcc_ram.sv]
`default_nettype none
module dcc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

[rtl/dcc_front.sv]
`default_nettype none
module dcc_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic              func,
   input  wire logic [63:0]       context_index,
   input  wire logic [1:0]        symbol,
   input  wire logic              clearing,
   input  wire logic              q_full,
   output      logic              full,
   output      logic              q_push,
   output      dcc_pkg::item_type q_item
);
   localparam int N = dcc_pkg::FRONT_STAGES;

   logic [N-1:0]                       v_ff;
   logic [63:0]                        z_ff    [N];
   logic                               func_ff [N];
   logic [1:0]                         sym_ff  [N];
   logic [dcc_pkg::CTX_BITS-1:0]       ctx_ff  [N];
   logic                               en;
   logic                               accept;

   assign en     = !v_ff[N-1] || !q_full;
   assign full   = !en || clearing;
   assign accept = push && !full;
   assign q_push = v_ff[N-1] && !q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[N-2:0], accept};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         z_ff[0]    <= dcc_pkg::mix_a(context_index);
         z_ff[1]    <= dcc_pkg::mix_b(z_ff[0]);
         z_ff[2]    <= dcc_pkg::mix_c(z_ff[1]);
         z_ff[3]    <= dcc_pkg::mix_d(z_ff[2]);
         func_ff[0] <= func;
         sym_ff[0]  <= symbol;
         ctx_ff[0]  <= context_index[dcc_pkg::CTX_BITS-1:0];
         for (int i = 1; i < N; i++) begin
            func_ff[i] <= func_ff[i-1];
            sym_ff[i]  <= sym_ff[i-1];
            ctx_ff[i]  <= ctx_ff[i-1];
         end
      end
   end

   always_comb begin
      q_item.func   = func_ff[N-1];
      q_item.symbol = sym_ff[N-1];
      q_item.ctx    = ctx_ff[N-1];
      q_item.hbits  = z_ff[N-1][dcc_pkg::HKEEP-1:0];
   end
endmodule
`default_nettype wire

[rtl/dcc_queue.sv]
`default_nettype none
module dcc_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire dcc_pkg::item_type push_item,
   input  wire logic              pop,
   output      logic              full,
   output      logic              empty,
   output      dcc_pkg::item_type head
);
   dcc_pkg::item_type mem_ff [2];
   logic              wr_ff;
   logic              rd_ff;
   logic [1:0]        count_ff;
   logic              do_push;
   logic              do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ff <= !wr_ff;
         end
         if (do_pop) begin
            rd_ff <= !rd_ff;
         end
         count_ff <= count_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end
endmodule
`default_nettype wire

[rtl/dcc_back.sv]
`default_nettype none
module dcc_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire dcc_pkg::cfg_type       cfg,
   input  wire logic                   q_empty,
   input  wire dcc_pkg::item_type      q_item,
   output      logic                   q_pop,
   input  wire logic                   pop,
   output      logic                   empty,
   output      dcc_pkg::result_type    result,
   output      dcc_pkg::back_status_type status
);
   localparam int BB = dcc_pkg::BUCKET_BITS;
   localparam int EB = dcc_pkg::ENTRY_BITS;
   localparam int NB = dcc_pkg::NCNT_BITS;
   localparam int CB = dcc_pkg::COUNTER_BITS;
   localparam int WB = dcc_pkg::WAY_BITS;
   localparam int KB = dcc_pkg::KEY_BITS;
   localparam int S  = dcc_pkg::SYMS;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_ISSUE = 3'b010,
      ST_EXEC  = 3'b100
   } state_type;

   state_type                       state_ff;
   state_type                       state_in;
   logic [dcc_pkg::CLR_BITS-1:0]    clr_ff;
   dcc_pkg::item_type               item_ff;

   logic                            rd_en;
   logic [dcc_pkg::ACNT_BITS-1:0]   arr_rd;
   logic [dcc_pkg::ROW_BITS-1:0]    row_rd;
   logic [WB-1:0]                   ptr_rd;
   logic                            arr_we, row_we, ptr_we;
   logic [dcc_pkg::CTX_BITS-1:0]    arr_wa;
   logic [BB-1:0]                   row_wa;
   logic [dcc_pkg::ACNT_BITS-1:0]   arr_wd;
   logic [dcc_pkg::ROW_BITS-1:0]    row_wd;
   logic [WB-1:0]                   ptr_wd;

   logic [dcc_pkg::WAYS_W-1:0]      ways_eff;
   logic [KB-1:0]                   tag;
   logic [EB-1:0]                   ent [dcc_pkg::MAX_WAYS];
   logic                            found;
   logic [WB-1:0]                   at;
   logic [NB-1:0]                   c, c_h, c_new;
   logic [3:0]                      v;
   logic [dcc_pkg::WAYS_W-1:0]      p;
   logic [dcc_pkg::ROW_BITS-1:0]    row_new;
   logic [CB-1:0]                   acnt [S];
   logic [CB-1:0]                   inc;
   logic [dcc_pkg::ACNT_BITS-1:0]   arr_new;
   logic [CB-1:0]                   lk_cnt [S];
   logic                            lk_hit;
   logic                            is_upd;
   logic                            go;

   logic                            res_v_ff;
   logic [CB-1:0]                   res_cnt_ff [S];
   logic                            res_hit_ff;
   logic                            res_free;
   logic                            res_move;
   dcc_pkg::result_type             res_out;

   dcc_pkg::result_type             ob_ff [2];
   logic                            ob_wr_ff, ob_rd_ff;
   logic [1:0]                      ob_cnt_ff;
   logic                            ob_pop;

   assign rd_en = (state_ff == ST_ISSUE) && !q_empty;
   assign q_pop = rd_en;
   assign is_upd = (item_ff.func == dcc_pkg::FUNC_UPDATE);
   assign res_move = res_v_ff && (ob_cnt_ff != 2'd2);
   assign res_free = !res_v_ff || res_move;
   assign go = (state_ff == ST_EXEC) && (is_upd || res_free);

   dcc_ram #(.WIDTH(dcc_pkg::ACNT_BITS), .DEPTH(dcc_pkg::ARRAY_CONTEXTS)) u_arr (
      .clock(clock), .we(arr_we), .waddr(arr_wa), .wdata(arr_wd),
      .re(rd_en), .raddr(q_item.ctx), .rdata(arr_rd)
   );
   dcc_ram #(.WIDTH(dcc_pkg::ROW_BITS), .DEPTH(dcc_pkg::BUCKETS)) u_row (
      .clock(clock), .we(row_we), .waddr(row_wa), .wdata(row_wd),
      .re(rd_en), .raddr(q_item.hbits[BB-1:0]), .rdata(row_rd)
   );
   dcc_ram #(.WIDTH(WB), .DEPTH(dcc_pkg::BUCKETS)) u_ptr (
      .clock(clock), .we(ptr_we), .waddr(row_wa), .wdata(ptr_wd),
      .re(rd_en), .raddr(q_item.hbits[BB-1:0]), .rdata(ptr_rd)
   );

   always_comb begin
      if (cfg.ways_in_use == '0) begin
         ways_eff = dcc_pkg::WAYS_W'(1);
      end else if (cfg.ways_in_use > dcc_pkg::WAYS_W'(dcc_pkg::MAX_WAYS)) begin
         ways_eff = dcc_pkg::WAYS_W'(dcc_pkg::MAX_WAYS);
      end else begin
         ways_eff = dcc_pkg::WAYS_W'(cfg.ways_in_use);
      end
      tag   = item_ff.hbits[KB-1:0];
      found = 1'b0;
      at    = '0;
      for (int i = 0; i < dcc_pkg::MAX_WAYS; i++) begin
         ent[i] = row_rd[i*EB +: EB];
      end
      for (int i = dcc_pkg::MAX_WAYS - 1; i >= 0; i--) begin
         if ((ent[i][EB-1:NB] == tag) && (dcc_pkg::WAYS_W'(i) < ways_eff)) begin
            found = 1'b1;
            at    = WB'(i);
         end
      end
      c = ent[at][NB-1:0];
      v = c[item_ff.symbol*4 +: 4];
      for (int s = 0; s < S; s++) begin
         c_h[s*4 +: 4] = (v == 4'hF) ? (c[s*4 +: 4] >> 1) : c[s*4 +: 4];
      end
      c_new = c_h;
      c_new[item_ff.symbol*4 +: 4] = c_h[item_ff.symbol*4 +: 4] + 4'd1;
      p = dcc_pkg::WAYS_W'(ptr_rd) + dcc_pkg::WAYS_W'(1);
      if (p >= ways_eff) begin
         p = '0;
      end
      row_new = row_rd;
      if (found) begin
         row_new[at*EB +: NB] = c_new;
      end else begin
         row_new[p[WB-1:0]*EB +: EB] = {tag, NB'(1) << (item_ff.symbol * 4)};
      end

      for (int s = 0; s < S; s++) begin
         acnt[s] = arr_rd[s*CB +: CB];
      end
      inc = acnt[item_ff.symbol] + CB'(1);
      for (int s = 0; s < S; s++) begin
         arr_new[s*CB +: CB] = (s == int'(item_ff.symbol)) ? inc : acnt[s];
         if (inc == cfg.max_count) begin
            arr_new[s*CB +: CB] = ((s == int'(item_ff.symbol)) ? inc : acnt[s]) >> 1;
         end
      end

      lk_hit = (cfg.hash_mode == dcc_pkg::MODE_ARRAY) ? 1'b1 : found;
      for (int s = 0; s < S; s++) begin
         if (cfg.hash_mode == dcc_pkg::MODE_ARRAY) begin
            lk_cnt[s] = acnt[s];
         end else if (found) begin
            lk_cnt[s] = CB'(c[s*4 +: 4]);
         end else begin
            lk_cnt[s] = '0;
         end
      end
   end

   always_comb begin
      arr_we = 1'b0;
      row_we = 1'b0;
      ptr_we = 1'b0;
      arr_wa = item_ff.ctx;
      row_wa = item_ff.hbits[BB-1:0];
      arr_wd = arr_new;
      row_wd = row_new;
      ptr_wd = p[WB-1:0];
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            arr_we = 1'b1;
            row_we = 1'b1;
            ptr_we = 1'b1;
            arr_wa = clr_ff;
            row_wa = clr_ff[BB-1:0];
            arr_wd = '0;
            row_wd = '0;
            ptr_wd = '0;
            if (clr_ff == '1) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (rd_en) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (go) begin
               state_in = ST_ISSUE;
               if (is_upd) begin
                  arr_we = (cfg.hash_mode == dcc_pkg::MODE_ARRAY);
                  row_we = (cfg.hash_mode != dcc_pkg::MODE_ARRAY);
                  ptr_we = (cfg.hash_mode != dcc_pkg::MODE_ARRAY) && !found;
               end
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         res_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (go && !is_upd) begin
            res_v_ff <= 1'b1;
         end else if (res_move) begin
            res_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         item_ff <= q_item;
      end
      if (go && !is_upd) begin
         res_cnt_ff <= lk_cnt;
         res_hit_ff <= lk_hit;
      end
   end

   always_comb begin
      res_out.wtotal = '0;
      res_out.ptotal = '0;
      for (int s = 0; s < S; s++) begin
         res_out.wfreq[s] = 28'(cfg.alpha_den) * 28'(res_cnt_ff[s]) + 28'd1;
         res_out.pfreq[s] = 17'(res_cnt_ff[s]) + 17'd1;
         res_out.wtotal   = res_out.wtotal + 30'(res_out.wfreq[s]);
         res_out.ptotal   = res_out.ptotal + 19'(res_out.pfreq[s]);
      end
      res_out.hit = res_hit_ff;
   end

   assign ob_pop = pop && (ob_cnt_ff != 2'd0);
   assign empty  = (ob_cnt_ff == 2'd0);
   assign result = ob_ff[ob_rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         ob_wr_ff  <= 1'b0;
         ob_rd_ff  <= 1'b0;
         ob_cnt_ff <= 2'd0;
      end else begin
         if (res_move) begin
            ob_wr_ff <= !ob_wr_ff;
         end
         if (ob_pop) begin
            ob_rd_ff <= !ob_rd_ff;
         end
         ob_cnt_ff <= ob_cnt_ff + {1'b0, res_move} - {1'b0, ob_pop};
      end
   end

   always_ff @(posedge clock) begin
      if (res_move) begin
         ob_ff[ob_wr_ff] <= res_out;
      end
   end

   assign status.clearing  = (state_ff == ST_CLEAR);
   assign status.rsp_count = ob_cnt_ff;
endmodule
`default_nettype wire

[rtl/dna_context_counter_model_core.sv]
// Symbol counters for a four-letter alphabet, kept per context, either in a
// direct array or in a bucketed hash table with several ways.
// Input beats arrive on push/full and carry func, context_index and symbol.
// A lookup beat yields one result beat on empty/pop; an update beat yields none.
// Configuration registers are written through csr_write_enable, csr_index and
// csr_write_data; the user must write them only while the block is idle,
// which the block itself does not enforce; a write is registered before it acts.
// A beat passes four hash stages and a two-entry queue; the back end reads the
// counter stores in its issue state, modifies and writes them back in its exec
// state, and takes no new beat until that write-back is done.
// After reset the back end clears all stores, stepping through all 65536 array
// addresses; full is high during that pass and beats are taken once it ends.
// When the receiver stops popping, results wait in a two-entry output queue,
// the back end stalls, and full rises once the input queue and stages fill.
`default_nettype none
module dna_context_counter_model_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output      logic        full,
   input  wire logic        req_func,
   input  wire logic [63:0] req_context_index,
   input  wire logic [1:0]  req_symbol,
   output      logic        empty,
   input  wire logic        pop,
   output      logic [27:0] rsp_weighted_freq_0,
   output      logic [27:0] rsp_weighted_freq_1,
   output      logic [27:0] rsp_weighted_freq_2,
   output      logic [27:0] rsp_weighted_freq_3,
   output      logic [29:0] rsp_weighted_total,
   output      logic [16:0] rsp_plain_freq_0,
   output      logic [16:0] rsp_plain_freq_1,
   output      logic [16:0] rsp_plain_freq_2,
   output      logic [16:0] rsp_plain_freq_3,
   output      logic [18:0] rsp_plain_total,
   output      logic        rsp_key_hit,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_write_data
);
   dcc_pkg::cfg_type           cfg_ff;
   dcc_pkg::item_type          f_item;
   dcc_pkg::item_type          q_head;
   dcc_pkg::result_type        res;
   dcc_pkg::back_status_type   status;
   logic                       f_push, q_full, q_empty, q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hash_mode   <= 1'b0;
         cfg_ff.ways_in_use <= 5'd16;
         cfg_ff.alpha_den   <= 12'd1;
         cfg_ff.max_count   <= 16'hFFFF;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            dcc_pkg::CSR_TABLE_MODE:  cfg_ff.hash_mode   <= csr_write_data[0];
            dcc_pkg::CSR_WAYS_IN_USE: cfg_ff.ways_in_use <= csr_write_data[4:0];
            dcc_pkg::CSR_ALPHA_DEN:   cfg_ff.alpha_den   <= csr_write_data[11:0];
            dcc_pkg::CSR_MAX_COUNT:   cfg_ff.max_count   <= csr_write_data;
            default: ;
         endcase
      end
   end

   dcc_front u_front (
      .clock(clock), .reset(reset), .push(push), .func(req_func),
      .context_index(req_context_index), .symbol(req_symbol),
      .clearing(status.clearing), .q_full(q_full), .full(full),
      .q_push(f_push), .q_item(f_item)
   );

   dcc_queue u_queue (
      .clock(clock), .reset(reset), .push(f_push), .push_item(f_item),
      .pop(q_pop), .full(q_full), .empty(q_empty), .head(q_head)
   );

   dcc_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .q_empty(q_empty),
      .q_item(q_head), .q_pop(q_pop), .pop(pop), .empty(empty),
      .result(res), .status(status)
   );

   assign rsp_weighted_freq_0 = res.wfreq[0];
   assign rsp_weighted_freq_1 = res.wfreq[1];
   assign rsp_weighted_freq_2 = res.wfreq[2];
   assign rsp_weighted_freq_3 = res.wfreq[3];
   assign rsp_weighted_total  = res.wtotal;
   assign rsp_plain_freq_0    = res.pfreq[0];
   assign rsp_plain_freq_1    = res.pfreq[1];
   assign rsp_plain_freq_2    = res.pfreq[2];
   assign rsp_plain_freq_3    = res.pfreq[3];
   assign rsp_plain_total     = res.ptotal;
   assign rsp_key_hit         = res.hit;

   a_clear_blocks_input: assert property (@(posedge clock) disable iff (reset)
      status.clearing |-> full) else $error("beat accepted during clearing pass");

   a_clear_no_result: assert property (@(posedge clock) disable iff (reset)
      status.clearing |-> empty) else $error("result present during clearing pass");

   a_miss_is_flat: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_key_hit) |-> (rsp_plain_total == 19'd4 && rsp_weighted_total == 30'd4))
      else $error("hash miss with nonzero counts");

   a_array_hits: assert property (@(posedge clock) disable iff (reset)
      (!empty && cfg_ff.hash_mode == dcc_pkg::MODE_ARRAY) |-> rsp_key_hit)
      else $error("array mode result without hit");

   a_count_match: assert property (@(posedge clock) disable iff (reset)
      empty |-> (status.rsp_count == 2'd0)) else $error("empty disagrees with output count");
endmodule
`default_nettype wire
